[sv/apu_pkg.sv]
`default_nettype none
package apu_pkg;

  localparam int ELEM_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(ELEM_DEPTH);
  // root bits per stage: two, so 16 stages for a 32-bit root
  localparam int SQ_STAGES  = 16;
  // quotient bits per stage: two, so 21 stages for 42 bits
  localparam int DV_STAGES  = 21;
  localparam int Q_W        = 2 * DV_STAGES;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    REG_BETA_FIRST    = 3'd0,
    REG_BETA_SECOND   = 3'd1,
    REG_LEARNING_RATE = 3'd2,
    REG_EPSILON       = 3'd3,
    REG_BIAS_FIRST    = 3'd4,
    REG_BIAS_SECOND   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] beta_first;
    logic [15:0] beta_second;
    logic [23:0] learning_rate;
    logic [15:0] epsilon;
    logic [31:0] bias_recip_first;
    logic [31:0] bias_recip_second;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic signed [31:0] mn;
    logic signed [31:0] vn;
  } mom_t;

  typedef struct packed {
    logic               neg;
    logic signed [31:0] val;
    logic [47:0]        mhat;
  } pay_t;

  typedef struct packed {
    pay_t        pay;
    logic [46:0] vhat;
  } hat_t;

  typedef struct packed {
    pay_t        pay;
    logic [31:0] root;
  } root_t;

  typedef struct packed {
    logic               neg;
    logic signed [31:0] val;
    logic [Q_W:0]       s24;
  } step_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] x;
  } sq_t;

  typedef struct packed {
    logic [32:0]    rem;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] n;
  } dv_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'sh7FFFFFFF;
    else if (x < S32_MIN) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // divide by 65536, rounding half up
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic sq_t sqrt_step(input sq_t s);
    sq_t         r;
    logic [35:0] t;
    logic [35:0] trial;
    t     = {s.rem, s.x[63:62]};
    trial = {2'b00, s.root, 2'b01};
    r.x   = {s.x[61:0], 2'b00};
    if (t >= trial) begin
      r.rem  = 34'(t - trial);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = t[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t div_step(input dv_t s, input logic [32:0] den);
    dv_t         r;
    logic [33:0] t;
    t   = {s.rem, s.n[Q_W-1]};
    r.n = {s.n[Q_W-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      r.rem = 33'(t - {1'b0, den});
      r.q   = {s.q[Q_W-2:0], 1'b1};
    end else begin
      r.rem = t[32:0];
      r.q   = {s.q[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/apu_moment.sv]
`default_nettype none
module apu_moment (
  input  logic                 clk,
  input  logic                 rst_n,
  input  apu_pkg::cfg_t        cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [11:0]          up_index,
  input  logic signed [31:0]   up_gradient,
  input  logic signed [31:0]   up_value,
  input  logic                 up_restart,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output apu_pkg::mom_t        dn_data
);
  import apu_pkg::*;

  logic signed [31:0] m_mem [ELEM_DEPTH];
  logic signed [31:0] v_mem [ELEM_DEPTH];

  logic              clr_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic [4:0] vld_r;
  logic [4:0] go;
  logic       hazard;
  logic       take;
  logic [ADDR_W-1:0] in_idx;

  logic [ADDR_W-1:0]  s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r;
  logic signed [31:0] s1_g_r, s1_val_r, s2_val_r, s3_val_r, s4_val_r;
  logic               s1_rs_r;
  logic signed [31:0] m_rd_r, v_rd_r;
  logic signed [48:0] s2_pm1_r;
  logic signed [49:0] s2_pm2_r;
  logic signed [63:0] s2_gg_r;
  logic signed [31:0] s2_v_r, s3_v_r;
  logic signed [31:0] s3_mn_r, s4_mn_r;
  logic [30:0]        s3_g2_r;
  logic signed [48:0] s4_pv1_r;
  logic signed [49:0] s4_pv2_r;
  mom_t               s5_r;

  logic signed [31:0] m_sel, v_sel;
  logic signed [48:0] pm1_nxt, pv1_nxt;
  logic signed [49:0] pm2_nxt, pv2_nxt;
  logic signed [63:0] gg_nxt, gr;
  logic signed [31:0] mn_nxt, vn_nxt;
  logic [30:0]        g2_nxt;
  logic [16:0]        omb1, omb2;

  assign in_idx = up_index[ADDR_W-1:0];

  // an item may not read an element whose update is still in flight
  assign hazard = (vld_r[0] && s1_idx_r == in_idx) || (vld_r[1] && s2_idx_r == in_idx) ||
                  (vld_r[2] && s3_idx_r == in_idx) || (vld_r[3] && s4_idx_r == in_idx);

  always_comb begin
    go[4] = !vld_r[4] || dn_ready;
    for (int i = 3; i >= 0; i--) go[i] = !vld_r[i] || go[i+1];
  end

  assign up_ready = go[0] && !hazard && !clr_r;
  assign take     = up_valid && up_ready;
  assign dn_valid = vld_r[4];
  assign dn_data  = s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      vld_r     <= '0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(ELEM_DEPTH - 1)) clr_r <= 1'b0;
      end
      if (go[0]) vld_r[0] <= take;
      for (int i = 1; i < 5; i++) begin
        if (go[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      m_mem[clr_cnt_r] <= '0;
      v_mem[clr_cnt_r] <= '0;
    end else if (go[4] && vld_r[3]) begin
      m_mem[s4_idx_r] <= s4_mn_r;
      v_mem[s4_idx_r] <= vn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      m_rd_r <= m_mem[in_idx];
      v_rd_r <= v_mem[in_idx];
    end
  end

  assign omb1 = 17'(17'h10000 - {1'b0, cfg.beta_first});
  assign omb2 = 17'(17'h10000 - {1'b0, cfg.beta_second});

  always_comb begin
    m_sel   = s1_rs_r ? 32'sd0 : m_rd_r;
    v_sel   = s1_rs_r ? 32'sd0 : v_rd_r;
    pm1_nxt = 49'($signed({1'b0, cfg.beta_first})) * 49'(m_sel);
    pm2_nxt = 50'($signed({1'b0, omb1})) * 50'(s1_g_r);
    gg_nxt  = 64'(s1_g_r) * 64'(s1_g_r);
    mn_nxt  = sat32(rnd16(64'(s2_pm1_r) + 64'(s2_pm2_r)));
    gr      = rnd16(s2_gg_r);
    g2_nxt  = (gr > S32_MAX) ? 31'h7FFFFFFF : gr[30:0];
    pv1_nxt = 49'($signed({1'b0, cfg.beta_second})) * 49'(s3_v_r);
    pv2_nxt = 50'($signed({1'b0, omb2})) * 50'($signed({1'b0, s3_g2_r}));
    vn_nxt  = sat32(rnd16(64'(s4_pv1_r) + 64'(s4_pv2_r)));
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s1_idx_r <= in_idx;
      s1_g_r   <= up_gradient;
      s1_val_r <= up_value;
      s1_rs_r  <= up_restart;
    end
    if (go[1]) begin
      s2_idx_r <= s1_idx_r;
      s2_val_r <= s1_val_r;
      s2_pm1_r <= pm1_nxt;
      s2_pm2_r <= pm2_nxt;
      s2_gg_r  <= gg_nxt;
      s2_v_r   <= v_sel;
    end
    if (go[2]) begin
      s3_idx_r <= s2_idx_r;
      s3_val_r <= s2_val_r;
      s3_mn_r  <= mn_nxt;
      s3_g2_r  <= g2_nxt;
      s3_v_r   <= s2_v_r;
    end
    if (go[3]) begin
      s4_idx_r <= s3_idx_r;
      s4_val_r <= s3_val_r;
      s4_mn_r  <= s3_mn_r;
      s4_pv1_r <= pv1_nxt;
      s4_pv2_r <= pv2_nxt;
    end
    if (go[4]) begin
      s5_r.val <= s4_val_r;
      s5_r.mn  <= s4_mn_r;
      s5_r.vn  <= vn_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/apu_hat.sv]
`default_nettype none
module apu_hat (
  input  logic          clk,
  input  logic          rst_n,
  input  apu_pkg::cfg_t cfg,
  input  logic          up_valid,
  output logic          up_ready,
  input  apu_pkg::mom_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output apu_pkg::hat_t dn_data
);
  import apu_pkg::*;

  logic [1:0]         vld_r;
  logic [1:0]         go;
  logic               s1_neg_r;
  logic signed [31:0] s1_val_r;
  logic [63:0]        s1_pm_r;
  logic [62:0]        s1_pv_r;
  hat_t               s2_r;
  logic [31:0]        mag;
  logic [30:0]        vpos;
  logic [63:0]        mr, vr;

  assign go[1]    = !vld_r[1] || dn_ready;
  assign go[0]    = !vld_r[0] || go[1];
  assign up_ready = go[0];
  assign dn_valid = vld_r[1];
  assign dn_data  = s2_r;

  assign mag  = up_data.mn[31] ? 32'(32'd0 - up_data.mn) : up_data.mn;
  assign vpos = (up_data.vn > 32'sd0) ? up_data.vn[30:0] : 31'd0;
  assign mr   = s1_pm_r + 64'd32768;
  assign vr   = {1'b0, s1_pv_r} + 64'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) vld_r[0] <= up_valid;
      if (go[1]) vld_r[1] <= vld_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s1_neg_r <= up_data.mn[31];
      s1_val_r <= up_data.val;
      s1_pm_r  <= 64'(mag) * 64'(cfg.bias_recip_first);
      s1_pv_r  <= 63'(vpos) * 63'(cfg.bias_recip_second);
    end
    if (go[1]) begin
      s2_r.pay.neg  <= s1_neg_r;
      s2_r.pay.val  <= s1_val_r;
      s2_r.pay.mhat <= mr[63:16];
      s2_r.vhat     <= vr[62:16];
    end
  end

endmodule
`default_nettype wire

[sv/apu_sqrt.sv]
`default_nettype none
module apu_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  apu_pkg::hat_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output apu_pkg::root_t dn_data
);
  import apu_pkg::*;

  logic [SQ_STAGES-1:0] vld_r;
  logic [SQ_STAGES-1:0] go;
  sq_t                  sq_r   [SQ_STAGES];
  sq_t                  sq_nxt [SQ_STAGES];
  pay_t                 pay_r  [SQ_STAGES];
  sq_t                  sq_init;

  // radicand is vhat in Q16.16 shifted up once more by 16
  assign sq_init = '{rem: '0, root: '0, x: {1'b0, up_data.vhat, 16'd0}};

  always_comb begin
    go[SQ_STAGES-1] = !vld_r[SQ_STAGES-1] || dn_ready;
    for (int i = SQ_STAGES - 2; i >= 0; i--) go[i] = !vld_r[i] || go[i+1];
    sq_nxt[0] = sqrt_step(sqrt_step(sq_init));
    for (int i = 1; i < SQ_STAGES; i++) sq_nxt[i] = sqrt_step(sqrt_step(sq_r[i-1]));
  end

  assign up_ready = go[0];
  assign dn_valid = vld_r[SQ_STAGES-1];
  assign dn_data  = '{pay: pay_r[SQ_STAGES-1], root: sq_r[SQ_STAGES-1].root};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) vld_r[0] <= up_valid;
      for (int i = 1; i < SQ_STAGES; i++) begin
        if (go[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      sq_r[0]  <= sq_nxt[0];
      pay_r[0] <= up_data.pay;
    end
    for (int i = 1; i < SQ_STAGES; i++) begin
      if (go[i]) begin
        sq_r[i]  <= sq_nxt[i];
        pay_r[i] <= pay_r[i-1];
      end
    end
  end

endmodule
`default_nettype wire

[sv/apu_div.sv]
`default_nettype none
module apu_div (
  input  logic           clk,
  input  logic           rst_n,
  input  apu_pkg::cfg_t  cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  apu_pkg::root_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output apu_pkg::step_t dn_data
);
  import apu_pkg::*;

  typedef struct packed {
    logic               neg;
    logic signed [31:0] val;
    logic               cap;
    logic [32:0]        den;
  } dpay_t;

  localparam int N_W = Q_W + 30;

  logic               a_vld_r, b_vld_r, a_go, b_go;
  logic               a_neg_r, b_neg_r;
  logic signed [31:0] a_val_r, b_val_r;
  logic [32:0]        a_den_r, b_den_r;
  logic [55:0]        a_plo_r;
  logic [39:0]        a_phi_r;
  logic [N_W-1:0]     b_n_r;
  logic [32:0]        den_sum;

  logic [DV_STAGES-1:0] vld_r;
  logic [DV_STAGES-1:0] go;
  dv_t                  dv_r   [DV_STAGES];
  dv_t                  dv_nxt [DV_STAGES];
  dpay_t                pay_r  [DV_STAGES];
  dv_t                  dv_init;
  logic                 cap_init;

  // top bits of the numerator already at or above den: quotient reaches the cap
  assign cap_init = {3'd0, b_n_r[N_W-1:Q_W]} >= b_den_r;
  assign dv_init  = '{rem: {3'd0, b_n_r[N_W-1:Q_W]}, q: '0, n: b_n_r[Q_W-1:0]};
  assign den_sum  = {1'b0, up_data.root} + {17'd0, cfg.epsilon};

  always_comb begin
    go[DV_STAGES-1] = !vld_r[DV_STAGES-1] || dn_ready;
    for (int i = DV_STAGES - 2; i >= 0; i--) go[i] = !vld_r[i] || go[i+1];
    dv_nxt[0] = div_step(div_step(dv_init, b_den_r), b_den_r);
    for (int i = 1; i < DV_STAGES; i++) begin
      dv_nxt[i] = div_step(div_step(dv_r[i-1], pay_r[i-1].den), pay_r[i-1].den);
    end
  end

  assign b_go     = !b_vld_r || go[0];
  assign a_go     = !a_vld_r || b_go;
  assign up_ready = a_go;
  assign dn_valid = vld_r[DV_STAGES-1];

  always_comb begin
    dn_data.neg = pay_r[DV_STAGES-1].neg;
    dn_data.val = pay_r[DV_STAGES-1].val;
    dn_data.s24 = pay_r[DV_STAGES-1].cap ? {1'b1, {Q_W{1'b0}}}
                                         : {1'b0, dv_r[DV_STAGES-1].q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      if (a_go) a_vld_r <= up_valid;
      if (b_go) b_vld_r <= a_vld_r;
      if (go[0]) vld_r[0] <= b_vld_r;
      for (int i = 1; i < DV_STAGES; i++) begin
        if (go[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      a_neg_r <= up_data.pay.neg;
      a_val_r <= up_data.pay.val;
      a_den_r <= (den_sum == 33'd0) ? 33'd1 : den_sum;
      a_plo_r <= 56'(cfg.learning_rate) * 56'(up_data.pay.mhat[31:0]);
      a_phi_r <= 40'(cfg.learning_rate) * 40'(up_data.pay.mhat[47:32]);
    end
    if (b_go) begin
      b_neg_r <= a_neg_r;
      b_val_r <= a_val_r;
      b_den_r <= a_den_r;
      b_n_r   <= N_W'(a_plo_r) + {a_phi_r, 32'd0};
    end
    if (go[0]) begin
      dv_r[0]      <= dv_nxt[0];
      pay_r[0].neg <= b_neg_r;
      pay_r[0].val <= b_val_r;
      pay_r[0].cap <= cap_init;
      pay_r[0].den <= b_den_r;
    end
    for (int i = 1; i < DV_STAGES; i++) begin
      if (go[i]) begin
        dv_r[i]  <= dv_nxt[i];
        pay_r[i] <= pay_r[i-1];
      end
    end
  end

endmodule
`default_nettype wire

[sv/adam_parameter_update.sv]
`default_nettype none
// channel  | ports                                            | handshake
// input    | in_element_index in_gradient in_param_value     | in_valid / in_ready
//          | in_restart                                       |
// result   | out_new_value                                    | out_valid / out_ready
// config   | cfg_index cfg_data                               | cfg_we, no wait
//
// one item a cycle at full rate, unless a hazard or a stall holds it; 47 register stages
// (5 moment with the memory read in the first, 2 bias, 16 root at two bits a stage,
// 23 divide, 1 output).
// after reset the moment memories are swept to zero with in_ready low.
// an item whose element is still being updated in the moment stages waits until that update is written back.
// a stall on out_ready holds every stage; bubbles ahead of it still close up.
module adam_parameter_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        in_element_index,
  input  logic signed [31:0] in_gradient,
  input  logic signed [31:0] in_param_value,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import apu_pkg::*;

  cfg_t  cfg_r;
  mom_t  mom_data;
  hat_t  hat_data;
  root_t root_data;
  step_t step_data;
  logic  mom_valid, mom_ready, hat_valid, hat_ready;
  logic  root_valid, root_ready, step_valid, step_ready;

  logic               out_valid_r;
  logic signed [31:0] out_new_value_r;
  logic               out_go;
  logic [34:0]        s16;
  logic signed [36:0] res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beta_first        <= 16'd58982;
      cfg_r.beta_second       <= 16'd65470;
      cfg_r.learning_rate     <= 24'd16777;
      cfg_r.epsilon           <= 16'd1;
      cfg_r.bias_recip_first  <= 32'd65536;
      cfg_r.bias_recip_second <= 32'd65536;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BETA_FIRST:    cfg_r.beta_first        <= cfg_data[15:0];
        REG_BETA_SECOND:   cfg_r.beta_second       <= cfg_data[15:0];
        REG_LEARNING_RATE: cfg_r.learning_rate     <= cfg_data[23:0];
        REG_EPSILON:       cfg_r.epsilon           <= cfg_data[15:0];
        REG_BIAS_FIRST:    cfg_r.bias_recip_first  <= cfg_data;
        REG_BIAS_SECOND:   cfg_r.bias_recip_second <= cfg_data;
        default: ;
      endcase
    end
  end

  apu_moment u_moment (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .up_valid    (in_valid),
    .up_ready    (in_ready),
    .up_index    (in_element_index),
    .up_gradient (in_gradient),
    .up_value    (in_param_value),
    .up_restart  (in_restart),
    .dn_valid    (mom_valid),
    .dn_ready    (mom_ready),
    .dn_data     (mom_data)
  );

  apu_hat u_hat (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (mom_valid),
    .up_ready (mom_ready),
    .up_data  (mom_data),
    .dn_valid (hat_valid),
    .dn_ready (hat_ready),
    .dn_data  (hat_data)
  );

  apu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (hat_valid),
    .up_ready (hat_ready),
    .up_data  (hat_data),
    .dn_valid (root_valid),
    .dn_ready (root_ready),
    .dn_data  (root_data)
  );

  apu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (root_valid),
    .up_ready (root_ready),
    .up_data  (root_data),
    .dn_valid (step_valid),
    .dn_ready (step_ready),
    .dn_data  (step_data)
  );

  // round the Q.24 step to Q16.16 and apply against the sign of mhat
  assign s16 = 35'((step_data.s24 + 43'd128) >> 8);
  assign res = step_data.neg ? 37'(step_data.val) + $signed({2'b00, s16})
                             : 37'(step_data.val) - $signed({2'b00, s16});

  assign out_go     = !out_valid_r || out_ready;
  assign step_ready = out_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_go) begin
      out_valid_r <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_go) out_new_value_r <= sat32(64'(res));
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = out_new_value_r;

endmodule
`default_nettype wire

[verif/tb_adam_parameter_update.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_adam_parameter_update;
  import apu_pkg::*;

  localparam int LATENCY   = 48;
  localparam int STALL_MAX = 200000;
  localparam int N_RANDOM  = 1620;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [11:0]        in_element_index = '0;
  logic signed [31:0] in_gradient = '0;
  logic signed [31:0] in_param_value = '0;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_new_value;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  adam_parameter_update dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] p_beta1, p_beta2, p_eps;
  logic [23:0] p_lr;
  logic [31:0] p_bias1, p_bias2;
  logic signed [31:0] p_m [ELEM_DEPTH];
  logic signed [31:0] p_v [ELEM_DEPTH];

  logic signed [31:0] new_value_q [$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_long = 0;
  bit done_sending = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] round16(input logic signed [63:0] x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] adam_update(input logic [11:0] idx,
      input logic signed [31:0] g32, input logic signed [31:0] val32, input logic rs);
    logic signed [63:0] g, m, v, g2, mn, vn, b1, b2, res;
    logic [63:0] mag, mhat, vhat, root, den, q, r, s24, s16, cap;
    logic neg;
    cap = 64'd1 << 42;
    g = g32;
    m = rs ? 64'sd0 : 64'(p_m[idx]);
    v = rs ? 64'sd0 : 64'(p_v[idx]);
    b1 = {48'd0, p_beta1};
    b2 = {48'd0, p_beta2};
    mn = clamp32(round16(b1 * m + (64'sd65536 - b1) * g));
    g2 = round16(g * g);
    if (g2 > 64'sd2147483647) g2 = 64'sd2147483647;
    vn = clamp32(round16(b2 * v + (64'sd65536 - b2) * g2));
    p_m[idx] = mn[31:0];
    p_v[idx] = vn[31:0];
    neg = mn < 0;
    mag = neg ? -mn : mn;
    mhat = (mag * p_bias1 + 64'd32768) >> 16;
    vhat = vn > 0 ? ((vn * p_bias2 + 64'd32768) >> 16) : 64'd0;
    root = int_sqrt(vhat << 16);
    den = root + p_eps;
    if (den == 0) den = 1;
    q = mhat / den;
    r = mhat % den;
    if (q != 0 && p_lr > cap / q) s24 = cap;
    else begin
      s24 = p_lr * q + (p_lr * r) / den;
      if (s24 > cap) s24 = cap;
    end
    s16 = (s24 + 64'd128) >> 8;
    res = neg ? 64'(val32) + $signed(s16) : 64'(val32) - $signed(s16);
    return clamp32(res);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BETA_FIRST:    p_beta1 = data[15:0];
      REG_BETA_SECOND:   p_beta2 = data[15:0];
      REG_LEARNING_RATE: p_lr = data[23:0];
      REG_EPSILON:       p_eps = data[15:0];
      REG_BIAS_FIRST:    p_bias1 = data;
      REG_BIAS_SECOND:   p_bias2 = data;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (new_value_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // with has_exp clear the row is checked against the predictor only
  task automatic send_item(input logic [11:0] idx, input logic signed [31:0] g,
      input logic signed [31:0] val, input logic rs, input bit has_exp,
      input logic signed [31:0] exp_val);
    logic signed [31:0] pred;
    in_valid <= 1'b1;
    in_element_index <= idx;
    in_gradient <= g;
    in_param_value <= val;
    in_restart <= rs;
    do @(posedge clk); while (!in_ready);
    pred = adam_update(idx, g, val, rs);
    if (has_exp && pred !== exp_val) report_mismatch("directed row disagrees with predictor");
    new_value_q.push_back(has_exp ? exp_val : pred);
  endtask

  typedef struct {
    logic [11:0]        idx;
    logic signed [31:0] g;
    logic signed [31:0] val;
    logic               rs;
    bit                 has_exp;
    logic signed [31:0] exp_val;
  } row_t;

  row_t stim_table [] = '{
    '{12'd0,    32'sd0,           32'sd0,           1'b0, 1, 32'sd0},
    '{12'd1,    32'sd0,           32'sh7FFFFFFF,    1'b1, 1, 32'sh7FFFFFFF},
    '{12'd2,    32'sd0,           32'sh80000000,    1'b1, 1, 32'sh80000000},
    '{12'd4095, 32'sh7FFFFFFF,    32'sd65536,       1'b0, 0, 32'sd0},
    '{12'd4094, 32'sh80000000,    -32'sd65536,      1'b0, 0, 32'sd0},
    '{12'd4095, 32'sh7FFFFFFF,    32'sh80000000,    1'b0, 0, 32'sd0},
    '{12'd4095, 32'sh80000000,    32'sh7FFFFFFF,    1'b1, 0, 32'sd0},
    '{12'd3,    32'sd65536,       32'sd0,           1'b0, 0, 32'sd0},
    '{12'd3,    32'sd65536,       32'sd0,           1'b0, 0, 32'sd0},
    '{12'd3,    -32'sd65536,      32'sd0,           1'b0, 0, 32'sd0},
    '{12'd3,    32'sd1,           32'sd100,         1'b1, 0, 32'sd0},
    '{12'd5,    -32'sd1,          -32'sd100,        1'b0, 0, 32'sd0},
    '{12'd2048, 32'sh00FF00FF,    32'sh12345678,    1'b0, 0, 32'sd0},
    '{12'd2048, 32'shFF00FF00,    32'shEDCBA987,    1'b0, 0, 32'sd0}
  };

  // receiver stall pattern
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_long > 0) begin
        out_ready <= 1'b0;
        stall_long--;
      end else case ($urandom_range(0, 3))
        0: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (new_value_q.size() == 0) report_mismatch("unexpected result item");
        else begin
          logic signed [31:0] e;
          e = new_value_q.pop_front();
          if (out_new_value !== e)
            report_mismatch($sformatf("new_value got %h exp %h", out_new_value, e));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || done_sending)
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic random_gap;
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    logic [11:0] idx;
    logic signed [31:0] g, val;
    int burst;
    for (int i = 0; i < ELEM_DEPTH; i++) begin
      p_m[i] = 0;
      p_v[i] = 0;
    end
    p_beta1 = 16'd58982; p_beta2 = 16'd65470; p_lr = 24'd16777; p_eps = 16'd1;
    p_bias1 = 32'd65536; p_bias2 = 32'd65536;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i])
      send_item(stim_table[i].idx, stim_table[i].g, stim_table[i].val, stim_table[i].rs,
                stim_table[i].has_exp, stim_table[i].exp_val);
    in_valid <= 1'b0;
    drain();

    // extremes: zero epsilon with zero gradient hits the zero-denominator guard
    write_reg(REG_EPSILON, 32'd0);
    write_reg(REG_LEARNING_RATE, 32'hFFFFFF);
    send_item(12'd7, 32'sd0, 32'sd5, 1'b1, 1, 32'sd5);
    send_item(12'd8, 32'sh7FFFFFFF, 32'sd0, 1'b1, 0, 32'sd0);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_BETA_FIRST, 32'd0);
    write_reg(REG_BETA_SECOND, 32'd65535);
    write_reg(REG_BIAS_FIRST, 32'hFFFFFFFF);
    write_reg(REG_BIAS_SECOND, 32'd0);
    send_item(12'd9, 32'sd12345, 32'sd0, 1'b0, 0, 32'sd0);
    send_item(12'd9, -32'sd99999, 32'sd0, 1'b0, 0, 32'sd0);
    in_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_BETA_FIRST, 32'd58982); write_reg(REG_BETA_SECOND, 32'd65470);
          write_reg(REG_LEARNING_RATE, 32'd16777); write_reg(REG_EPSILON, 32'd1);
          write_reg(REG_BIAS_FIRST, 32'd65536); write_reg(REG_BIAS_SECOND, 32'd65536);
        end
        1: begin
          write_reg(REG_BETA_FIRST, 32'd65535); write_reg(REG_BETA_SECOND, 32'd0);
          write_reg(REG_EPSILON, 32'd65535); write_reg(REG_BIAS_SECOND, 32'hFFFFFFFF);
        end
        2: begin
          write_reg(REG_BETA_FIRST, $urandom_range(0, 65535));
          write_reg(REG_BETA_SECOND, $urandom_range(0, 65535));
          write_reg(REG_LEARNING_RATE, $urandom_range(0, 24'hFFFFFF));
          write_reg(REG_EPSILON, $urandom_range(0, 65535));
          write_reg(REG_BIAS_FIRST, $urandom);
          write_reg(REG_BIAS_SECOND, $urandom);
        end
        default: begin
          write_reg(REG_BETA_FIRST, 32'd58982); write_reg(REG_BETA_SECOND, 32'd65470);
          write_reg(REG_LEARNING_RATE, 32'd0); write_reg(REG_EPSILON, 32'd16);
          write_reg(REG_BIAS_FIRST, 32'd200000); write_reg(REG_BIAS_SECOND, 32'd80000);
        end
      endcase
      // long receiver hold-off while items keep coming
      if (phase == 1) stall_long = 300;
      burst = 0;
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        // mostly a small hot set so moments build up and hazards occur
        idx = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 7)) : 12'($urandom);
        case ($urandom_range(0, 5))
          0: g = $urandom;
          1: g = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
          default: g = $signed(32'($urandom_range(0, 262143))) - 32'sd131072;
        endcase
        val = ($urandom_range(0, 3) == 0) ? $urandom : $signed(32'($urandom_range(0, 2000000)))
              - 32'sd1000000;
        send_item(idx, g, val, ($urandom_range(0, 15) == 0), 0, 32'sd0);
        if (burst == 0) begin
          random_gap();
          burst = $urandom_range(1, 40);
        end else burst--;
      end
      in_valid <= 1'b0;
      drain();
    end

    done_sending = 1;
    drain();
    if (errors == 0 && new_value_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

[adam_parameter_update.f]
sv/apu_pkg.sv
sv/apu_moment.sv
sv/apu_hat.sv
sv/apu_sqrt.sv
sv/apu_div.sv
sv/adam_parameter_update.sv
verif/tb_adam_parameter_update.sv
